// ----- rtl/core/bpa_pkg.sv -----
// shared types, command codes and helpers for the buddy page allocator
`default_nettype none

package bpa_pkg;

    // fixed field widths of the streaming words
    localparam int CMD_W = 2;
    localparam int CNT_W = 11;
    localparam int OFF_W = 10;
    localparam int ORD_W = 4;
    localparam int REQ_W = CNT_W + 1;

    // command codes carried in the input word
    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_INIT  = 2'd2
    } bpa_cmd_t;

    // one finished result word
    typedef struct packed {
        logic             success;
        logic [OFF_W-1:0] block_offset;
        logic [CNT_W-1:0] granted_pages;
        logic [CNT_W-1:0] avail_pages;
    } bpa_result_t;

    // order of the smallest power of two not below the count, zero count gives order 0
    function automatic logic [ORD_W-1:0] req_order(input logic [CNT_W-1:0] count);
        logic [ORD_W-1:0] ord;
        ord = ORD_W'(CNT_W);
        for (int k = CNT_W; k >= 0; k--) begin
            if ((REQ_W'(1) << k) >= REQ_W'(count)) begin
                ord = ORD_W'(k);
            end
        end
        return ord;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bpa_tree_mem.sv -----
// node memory of the buddy tree, one write port and one registered read port
`default_nettype none

module bpa_tree_mem
    import bpa_pkg::*;
#(
    parameter int DEPTH = 2047,
    parameter int AW    = 11,
    parameter int VW    = 11
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [VW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [VW-1:0] rdata
);

    logic [VW-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/bpa_ctrl.sv -----
// command sequencer: tree fill, descent for alloc, climb with merge for free
`default_nettype none

module bpa_ctrl
    import bpa_pkg::*;
#(
    parameter int POOL_PAGES = 1024
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [CMD_W-1:0]                     in_cmd,
    input  wire logic [CNT_W-1:0]                     in_count,
    input  wire logic [OFF_W-1:0]                     in_offset,
    input  wire logic [ORD_W-1:0]                     pool_order,
    output logic                                      res_valid,
    input  wire logic                                 res_ready,
    output bpa_result_t                               res,
    output logic [$clog2(2*POOL_PAGES-1)-1:0]         mem_raddr,
    input  wire logic [$clog2(POOL_PAGES+1)-1:0]      mem_rdata,
    output logic                                      mem_we,
    output logic [$clog2(2*POOL_PAGES-1)-1:0]         mem_waddr,
    output logic [$clog2(POOL_PAGES+1)-1:0]           mem_wdata
);

    localparam int LOG   = $clog2(POOL_PAGES + 1) - 1;
    localparam int VW    = LOG + 1;
    localparam int DEPTH = 2 * POOL_PAGES - 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int OW    = $clog2(LOG + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALLOC_CHK,
        ST_DESC_RD,
        ST_DESC_CMP,
        ST_MARK,
        ST_FREE_START,
        ST_CLIMB_RD,
        ST_CLIMB_WR,
        ST_INIT_FILL,
        ST_FINISH
    } state_t;

    state_t           state_reg;
    bpa_cmd_t         cmd_reg;
    logic [REQ_W-1:0] r_reg;
    logic [ORD_W-1:0] rord_reg;
    logic [OFF_W-1:0] poff_reg;
    logic [AW-1:0]    idx_reg;
    logic [AW-1:0]    lvl_last_reg;
    logic [VW-1:0]    node_reg;
    logic [VW-1:0]    cur_reg;
    logic [VW-1:0]    off_reg;
    logic             ok_reg;
    logic             init_reg;
    logic [OW-1:0]    tord_reg;
    logic [VW-1:0]    tsize_reg;
    logic [VW-1:0]    free_reg;

    logic [ORD_W-1:0] in_ord;
    logic [OW-1:0]    size_ord;
    logic [VW-1:0]    init_size;
    logic [AW-1:0]    fill_end;
    logic [AW-1:0]    left_idx;
    logic [AW-1:0]    sib_idx;
    logic [AW-1:0]    parent_idx;
    logic [AW-1:0]    leaf_idx;
    logic [VW-1:0]    half_node;
    logic [VW-1:0]    parent_size;
    logic [VW:0]      pair_sum;
    logic [VW-1:0]    pair_max;
    logic [VW-1:0]    merged;
    logic [31:0]      free_sum;
    logic             alloc_ok;
    logic             free_ok;

    // request order and init pool size
    assign in_ord    = req_order(in_count);
    assign size_ord  = (32'(pool_order) > LOG) ? OW'(LOG) : OW'(pool_order);
    assign init_size = VW'(1) << size_ord;
    assign fill_end  = AW'({tsize_reg, 1'b0}) - AW'(2);

    // tree index arithmetic
    assign left_idx    = {idx_reg[AW-2:0], 1'b0} + AW'(1);
    assign sib_idx     = idx_reg[0] ? (idx_reg + AW'(1)) : (idx_reg - AW'(1));
    assign parent_idx  = (idx_reg - AW'(1)) >> 1;
    assign leaf_idx    = ((AW'(1) << (5'(tord_reg) - 5'(rord_reg))) - AW'(1))
                         + AW'(poff_reg >> rord_reg);
    assign half_node   = node_reg >> 1;
    assign parent_size = node_reg << 1;

    // parent value on the way up, buddies merge only on free
    assign pair_sum = (VW + 1)'(cur_reg) + (VW + 1)'(mem_rdata);
    assign pair_max = (cur_reg > mem_rdata) ? cur_reg : mem_rdata;
    assign merged   = (cmd_reg == CMD_FREE && pair_sum == (VW + 1)'(parent_size))
                      ? parent_size : pair_max;

    // admission checks
    assign alloc_ok = init_reg && (32'(r_reg) <= 32'(free_reg))
                      && (32'(r_reg) <= 32'(mem_rdata));
    assign free_ok  = init_reg && (32'(r_reg) <= 32'(tsize_reg))
                      && (32'(poff_reg) < 32'(tsize_reg));
    assign free_sum = 32'(free_reg) + 32'(r_reg);

    // memory access per state
    always_comb begin
        mem_raddr = AW'(0);
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = node_reg;
        case (state_reg)
            ST_DESC_RD: begin
                mem_raddr = left_idx;
            end
            ST_CLIMB_RD: begin
                mem_raddr = sib_idx;
            end
            ST_MARK: begin
                mem_we    = 1'b1;
                mem_wdata = VW'(0);
            end
            ST_FREE_START: begin
                mem_we    = free_ok;
                mem_waddr = leaf_idx;
                mem_wdata = VW'(r_reg);
            end
            ST_CLIMB_WR: begin
                mem_we    = 1'b1;
                mem_waddr = parent_idx;
                mem_wdata = merged;
            end
            ST_INIT_FILL: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_raddr = AW'(0);
            end
        endcase
    end

    // handshake and result word
    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_FINISH);

    always_comb begin
        res.success       = ok_reg;
        res.block_offset  = '0;
        res.granted_pages = ok_reg ? r_reg[CNT_W-1:0] : '0;
        res.avail_pages   = CNT_W'(free_reg);
        if (ok_reg) begin
            case (cmd_reg)
                CMD_ALLOC: res.block_offset = OFF_W'(off_reg);
                CMD_FREE:  res.block_offset = poff_reg & ~(r_reg[OFF_W-1:0] - OFF_W'(1));
                default:   res.block_offset = '0;
            endcase
            if (cmd_reg == CMD_INIT) begin
                res.granted_pages = '0;
            end
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            init_reg  <= 1'b0;
            free_reg  <= '0;
            ok_reg    <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        cmd_reg  <= bpa_cmd_t'(in_cmd);
                        rord_reg <= in_ord;
                        r_reg    <= REQ_W'(1) << in_ord;
                        poff_reg <= in_offset;
                        ok_reg   <= 1'b0;
                        case (in_cmd)
                            CMD_ALLOC: state_reg <= ST_ALLOC_CHK;
                            CMD_FREE:  state_reg <= ST_FREE_START;
                            CMD_INIT: begin
                                tord_reg     <= size_ord;
                                tsize_reg    <= init_size;
                                free_reg     <= init_size;
                                init_reg     <= 1'b1;
                                idx_reg      <= '0;
                                lvl_last_reg <= '0;
                                node_reg     <= init_size;
                                state_reg    <= ST_INIT_FILL;
                            end
                            default:   state_reg <= ST_FINISH;
                        endcase
                    end
                end
                ST_ALLOC_CHK: begin
                    // root word arrives here
                    if (alloc_ok) begin
                        ok_reg   <= 1'b1;
                        free_reg <= free_reg - VW'(r_reg);
                        idx_reg  <= '0;
                        off_reg  <= '0;
                        node_reg <= tsize_reg;
                        if (32'(tsize_reg) == 32'(r_reg)) begin
                            state_reg <= ST_MARK;
                        end else begin
                            state_reg <= ST_DESC_RD;
                        end
                    end else begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_DESC_RD: begin
                    state_reg <= ST_DESC_CMP;
                end
                ST_DESC_CMP: begin
                    // take the left child when it is large enough
                    if (32'(mem_rdata) >= 32'(r_reg)) begin
                        idx_reg <= left_idx;
                    end else begin
                        idx_reg <= left_idx + AW'(1);
                        off_reg <= off_reg + half_node;
                    end
                    node_reg <= half_node;
                    if (32'(half_node) == 32'(r_reg)) begin
                        state_reg <= ST_MARK;
                    end else begin
                        state_reg <= ST_DESC_RD;
                    end
                end
                ST_MARK: begin
                    cur_reg <= '0;
                    if (idx_reg == '0) begin
                        state_reg <= ST_FINISH;
                    end else begin
                        state_reg <= ST_CLIMB_RD;
                    end
                end
                ST_FREE_START: begin
                    if (free_ok) begin
                        ok_reg   <= 1'b1;
                        free_reg <= (free_sum > 32'(tsize_reg)) ? tsize_reg : VW'(free_sum);
                        idx_reg  <= leaf_idx;
                        cur_reg  <= VW'(r_reg);
                        node_reg <= VW'(r_reg);
                        if (leaf_idx == '0) begin
                            state_reg <= ST_FINISH;
                        end else begin
                            state_reg <= ST_CLIMB_RD;
                        end
                    end else begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_CLIMB_RD: begin
                    state_reg <= ST_CLIMB_WR;
                end
                ST_CLIMB_WR: begin
                    idx_reg  <= parent_idx;
                    cur_reg  <= merged;
                    node_reg <= parent_size;
                    if (parent_idx == '0) begin
                        state_reg <= ST_FINISH;
                    end else begin
                        state_reg <= ST_CLIMB_RD;
                    end
                end
                ST_INIT_FILL: begin
                    // one node a cycle, value halves at each level end
                    if (idx_reg == fill_end) begin
                        ok_reg    <= 1'b1;
                        state_reg <= ST_FINISH;
                    end else begin
                        if (idx_reg == lvl_last_reg) begin
                            node_reg     <= half_node;
                            lvl_last_reg <= {lvl_last_reg[AW-2:0], 1'b0} + AW'(2);
                        end
                        idx_reg <= idx_reg + AW'(1);
                    end
                end
                ST_FINISH: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/buddy_page_allocator_core.sv -----
// top level of the buddy page allocator: ports, pool order register, result word register
`default_nettype none

// Buddy page allocator over a binary tree of largest-free-block sizes held in one
// synchronous memory of 2*POOL_PAGES-1 words. Commands arrive one word at a time:
// allocate, free, or initialize a pool of 2^pool_order pages (capped at the largest
// power of two not above POOL_PAGES). One command is worked at a time; the memory's
// single registered read port sets the pace. An allocation descends level by level to
// the block size, clears that node and climbs back to the root refreshing each parent;
// a free writes the node of the freed block and climbs to the root, merging buddies
// that are both wholly free. A failed allocation or free and an unknown command finish
// without touching the tree, and initializing writes every node once. A finished
// result word waits while the output register is still full and stalled.
// The tree holds no meaningful data before the first initialize; allocations fail and
// frees are ignored until then. The next command word is taken while the previous
// result word still waits in the output register.
module buddy_page_allocator_core
    import bpa_pkg::*;
#(
    parameter int POOL_PAGES = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // command channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // page_count[10:0], page_offset[20:11], zero pad
    input  wire logic [1:0]  s_tuser,   // command[1:0]
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // block_offset[9:0], granted_pages[20:10],
                                        // avail_pages[31:21]
    output logic             m_tuser,   // success
    // pool order register
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_data
);

    localparam int LOG   = $clog2(POOL_PAGES + 1) - 1;
    localparam int VW    = LOG + 1;
    localparam int DEPTH = 2 * POOL_PAGES - 1;
    localparam int AW    = $clog2(DEPTH);

    logic [ORD_W-1:0] pool_order_reg;
    logic             m_tvalid_reg;
    bpa_result_t      m_word_reg;

    logic             res_valid;
    logic             res_ready;
    bpa_result_t      res;
    logic [AW-1:0]    mem_raddr;
    logic [VW-1:0]    mem_rdata;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VW-1:0]    mem_wdata;

    // pool order register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_order_reg <= ORD_W'(10);
        end else if (cfg_valid) begin
            pool_order_reg <= cfg_data;
        end
    end

    bpa_ctrl #(
        .POOL_PAGES (POOL_PAGES)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser),
        .in_count   (s_tdata[10:0]),
        .in_offset  (s_tdata[20:11]),
        .pool_order (pool_order_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata)
    );

    bpa_tree_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .VW    (VW)
    ) u_tree_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output word register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
            if (res_valid) begin
                m_word_reg <= res;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_word_reg.success;
    assign m_tdata  = {m_word_reg.avail_pages, m_word_reg.granted_pages,
                       m_word_reg.block_offset};

endmodule

`default_nettype wire

// ----- dv/tb_buddy_page_allocator_core.sv -----
// testbench for the buddy page allocator core: tree-based prediction and checking of every result word
`timescale 1ns / 100ps

module tb_buddy_page_allocator_core;
    import bpa_pkg::*;

    localparam int unsigned POOL_PAGES   = 1024;
    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned RANDOM_ITEMS = 150;

    // command code with no meaning to the block
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // receiver pacing modes
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_MOSTLY,
        RX_SPARSE,
        RX_LONG_STALL
    } rx_pace_t;

    // predicts the allocator tree and checks result words in order
    class alloc_scoreboard;
        int unsigned node_free [2*POOL_PAGES-1];
        int unsigned avail_pages;
        int unsigned pool_pages;
        logic [ORD_W-1:0] order_reg;
        bpa_result_t outcome_q[$];
        int unsigned failures;
        int unsigned checked;

        function new();
            avail_pages = 0;
            pool_pages  = 0;
            order_reg   = 4'd10;
            failures    = 0;
            checked     = 0;
        endfunction

        function void set_order(logic [ORD_W-1:0] ord);
            order_reg = ord;
        endfunction

        function int unsigned pending();
            return outcome_q.size();
        endfunction

        function int unsigned ceil_pow2(int unsigned c);
            int unsigned r;
            r = 1;
            while (r < c) r <<= 1;
            return r;
        endfunction

        // work out the result word of one accepted command
        function bpa_result_t note_command(logic [CMD_W-1:0] cmd, logic [CNT_W-1:0] cnt,
                                           logic [OFF_W-1:0] off);
            bpa_result_t res;
            int unsigned span, idx, blk, lv, rv, sz, lvl_first, lvl_len, i;
            span = ceil_pow2(32'(cnt));
            res = '0;
            case (cmd)
                CMD_INIT: begin
                    sz = 1 << order_reg;
                    while (sz > POOL_PAGES) sz >>= 1;
                    lvl_first = 0;
                    lvl_len = 1;
                    blk = sz;
                    while (blk >= 1) begin
                        for (i = 0; i < lvl_len; i++) node_free[lvl_first + i] = blk;
                        lvl_first += lvl_len;
                        lvl_len <<= 1;
                        blk >>= 1;
                    end
                    pool_pages  = sz;
                    avail_pages = sz;
                    res.success = 1'b1;
                end
                CMD_ALLOC: begin
                    if (pool_pages != 0 && span <= avail_pages && span <= node_free[0]) begin
                        // descend, left child first
                        idx = 0;
                        for (blk = pool_pages; blk > span; blk >>= 1) begin
                            idx = (node_free[2*idx+1] >= span) ? 2*idx+1 : 2*idx+2;
                        end
                        node_free[idx] = 0;
                        res.block_offset = OFF_W'((idx + 1) * blk - pool_pages);
                        // refresh ancestors
                        while (idx != 0) begin
                            idx = (idx - 1) / 2;
                            lv = node_free[2*idx+1];
                            rv = node_free[2*idx+2];
                            node_free[idx] = (lv > rv) ? lv : rv;
                        end
                        avail_pages -= span;
                        res.success = 1'b1;
                        res.granted_pages = CNT_W'(span);
                    end
                end
                CMD_FREE: begin
                    if (pool_pages != 0 && span <= pool_pages && off < pool_pages) begin
                        idx = pool_pages + off - 1;
                        blk = 1;
                        while (blk < span) begin
                            blk <<= 1;
                            idx = (idx - 1) / 2;
                        end
                        node_free[idx] = blk;
                        // climb, merging buddies that are both wholly free
                        while (idx != 0) begin
                            idx = (idx - 1) / 2;
                            blk <<= 1;
                            lv = node_free[2*idx+1];
                            rv = node_free[2*idx+2];
                            node_free[idx] = (lv + rv == blk) ? blk : ((lv > rv) ? lv : rv);
                        end
                        avail_pages += span;
                        if (avail_pages > pool_pages) avail_pages = pool_pages;
                        res.success = 1'b1;
                        res.block_offset = OFF_W'(off & ~(span - 1));
                        res.granted_pages = CNT_W'(span);
                    end
                end
                default: begin
                end
            endcase
            res.avail_pages = CNT_W'(avail_pages);
            outcome_q.push_back(res);
            return res;
        endfunction

        // compare one result word with the oldest prediction
        function void check_result(logic got_ok, logic [31:0] word);
            bpa_result_t want;
            if (outcome_q.size() == 0) begin
                $display("%0t: result word %h ok=%b with no prediction waiting", $time, word,
                         got_ok);
                failures++;
                return;
            end
            want = outcome_q.pop_front();
            checked++;
            if (got_ok !== want.success) begin
                $display("%0t: success expected %b actual %b", $time, want.success, got_ok);
                failures++;
            end
            if (word[9:0] !== want.block_offset) begin
                $display("%0t: block_offset expected %0d actual %0d", $time,
                         want.block_offset, word[9:0]);
                failures++;
            end
            if (word[20:10] !== want.granted_pages) begin
                $display("%0t: granted_pages expected %0d actual %0d", $time,
                         want.granted_pages, word[20:10]);
                failures++;
            end
            if (word[31:21] !== want.avail_pages) begin
                $display("%0t: avail_pages expected %0d actual %0d", $time,
                         want.avail_pages, word[31:21]);
                failures++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // page_count[10:0], page_offset[20:11], zero pad
    logic [1:0]  s_tuser;   // command[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // block_offset[9:0], granted_pages[20:10], avail_pages[31:21]
    logic        m_tuser;   // success
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;

    alloc_scoreboard sb;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned rx_hold = 0;
    rx_pace_t    rx_mode = RX_OPEN;
    int unsigned live_base[$];
    int unsigned live_size[$];
    int unsigned n_words = 0;
    int unsigned n_grants = 0;
    int unsigned n_frees = 0;
    int unsigned n_inits = 0;
    int unsigned n_orders = 0;

    buddy_page_allocator_core #(
        .POOL_PAGES(POOL_PAGES)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // cycle counter and watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected", cycle_count,
                     sb.pending());
            $display("buddy_page_allocator_core test failed");
            $finish;
        end
    end

    // receiver stall pattern, mode picked at random whenever its hold count runs out
    always @(posedge aclk) begin
        if (rx_hold == 0) begin
            rx_mode <= rx_pace_t'($urandom_range(0, 3));
            rx_hold <= $urandom_range(64, 256);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_MOSTLY: m_tready <= (cycle_count[1:0] != 2'b11);
            RX_SPARSE: m_tready <= ($urandom_range(0, 9) < 3);
            default:   m_tready <= (cycle_count[5:0] >= 6'd40);
        endcase
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tuser, m_tdata);
        end
    end

    // offer one command word and hold it until taken
    task automatic send_word(input logic [CMD_W-1:0] cmd, input int unsigned cnt,
                             input int unsigned off);
        bpa_result_t want;
        logic [CNT_W-1:0] cnt_w;
        logic [OFF_W-1:0] off_w;
        cnt_w = CNT_W'(cnt);
        off_w = OFF_W'(off);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, off_w, cnt_w};
        do @(posedge aclk); while (!s_tready);
        want = sb.note_command(cmd, cnt_w, off_w);
        n_words++;
        if (cmd == CMD_INIT) begin
            n_inits++;
            live_base.delete();
            live_size.delete();
        end else if (cmd == CMD_ALLOC && want.success) begin
            n_grants++;
            live_base.push_back(32'(want.block_offset));
            live_size.push_back(32'(want.granted_pages));
        end else if (cmd == CMD_FREE && want.success) begin
            n_frees++;
        end
    endtask

    // sender bursts with random gaps between them
    task automatic pace_sender(input bit steady);
        int unsigned gap;
        if (!steady) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
    endtask

    // let every predicted word come back, then let the block settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_pool_order(input logic [ORD_W-1:0] ord);
        cfg_valid <= 1'b1;
        cfg_data  <= ord;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_order(ord);
        n_orders++;
    endtask

    // one pool order: mostly alloc/free pairs on live blocks, some noise
    task automatic run_random_phase(input logic [ORD_W-1:0] ord, input int unsigned n_items,
                                    input bit steady);
        int unsigned pool_log, k, j, roll, cnt, off, g, n;
        wait_drained();
        write_pool_order(ord);
        pool_log = (ord > 10) ? 10 : ord;
        pace_sender(steady);
        send_word(CMD_INIT, $urandom_range(0, 2047), $urandom_range(0, 1023));
        for (n = 0; n < n_items; n++) begin
            roll = $urandom_range(0, 99);
            pace_sender(steady);
            if (roll >= 45 && roll < 80 && live_base.size() != 0) begin
                // release a live block, sometimes by a page inside it
                j = $urandom_range(0, live_base.size() - 1);
                g = live_size[j];
                off = live_base[j];
                cnt = $urandom_range(g / 2 + 1, g);
                if ($urandom_range(0, 3) == 0) off += $urandom_range(0, g - 1);
                live_base.delete(j);
                live_size.delete(j);
                send_word(CMD_FREE, cnt, off);
            end else if (roll < 80) begin
                // request biased toward small blocks
                k = $urandom_range(0, pool_log);
                if ($urandom_range(0, 1) == 1) k = $urandom_range(0, k);
                cnt = (k == 0) ? $urandom_range(0, 1) : $urandom_range((1 << k) / 2 + 1, 1 << k);
                send_word(CMD_ALLOC, cnt, $urandom_range(0, 1023));
            end else if (roll < 88) begin
                cnt = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 2047) : $urandom_range(0, 8);
                send_word(CMD_FREE, cnt, $urandom_range(0, 1023));
            end else if (roll < 94) begin
                send_word(CMD_ALLOC, $urandom_range(0, 2047), $urandom_range(0, 1023));
            end else if (roll < 97) begin
                send_word(CMD_UNUSED, $urandom_range(0, 2047), $urandom_range(0, 1023));
            end else if (roll < 99) begin
                send_word(CMD_INIT, $urandom_range(0, 2047), $urandom_range(0, 1023));
            end else begin
                // release the whole pool at once
                send_word(CMD_FREE, 1 << pool_log, 0);
                live_base.delete();
                live_size.delete();
            end
        end
    endtask

    // stimulus
    initial begin
        sb = new();
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= 4'd10;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // commands before any init, then corner cases on the full pool
        send_word(CMD_ALLOC, 1, 0);
        send_word(CMD_FREE, 1, 0);
        send_word(CMD_UNUSED, 0, 0);
        send_word(CMD_INIT, 0, 0);
        send_word(CMD_ALLOC, 0, 0);
        send_word(CMD_ALLOC, 1024, 0);
        send_word(CMD_ALLOC, 3, 0);
        send_word(CMD_ALLOC, 2047, 1023);
        send_word(CMD_FREE, 4, 6);
        send_word(CMD_FREE, 0, 0);
        send_word(CMD_FREE, 1, 0);
        send_word(CMD_ALLOC, 1024, 0);
        send_word(CMD_ALLOC, 1, 0);
        send_word(CMD_FREE, 1024, 0);
        send_word(CMD_FREE, 1025, 0);
        send_word(CMD_FREE, 1, 1023);
        send_word(CMD_UNUSED, 2047, 1023);

        // oversized order saturates to the largest pool
        wait_drained();
        write_pool_order(4'd15);
        send_word(CMD_INIT, 2047, 1023);
        send_word(CMD_ALLOC, 512, 0);
        send_word(CMD_FREE, 2, 1023);

        // two-page pool: offsets past the end and oversized requests
        wait_drained();
        write_pool_order(4'd1);
        send_word(CMD_INIT, 0, 0);
        send_word(CMD_FREE, 1, 2);
        send_word(CMD_ALLOC, 4, 0);
        send_word(CMD_ALLOC, 2, 0);

        // single-page pool
        wait_drained();
        write_pool_order(4'd0);
        send_word(CMD_INIT, 0, 0);
        send_word(CMD_ALLOC, 1, 0);

        // random phases over a spread of pool orders
        run_random_phase(4'd10, RANDOM_ITEMS, 1'b0);
        run_random_phase(4'd1,  RANDOM_ITEMS, 1'b0);
        run_random_phase(4'd0,  RANDOM_ITEMS, 1'b1);
        run_random_phase(4'd5,  RANDOM_ITEMS, 1'b0);
        run_random_phase(4'd15, RANDOM_ITEMS, 1'b0);
        run_random_phase(4'd3,  RANDOM_ITEMS, 1'b1);
        run_random_phase(4'd8,  RANDOM_ITEMS, 1'b0);
        run_random_phase(4'd2,  RANDOM_ITEMS, 1'b0);
        run_random_phase(4'd12, RANDOM_ITEMS, 1'b1);
        run_random_phase(4'd7,  RANDOM_ITEMS, 1'b0);
        run_random_phase(4'd10, RANDOM_ITEMS, 1'b0);

        wait_drained();
        $display("covered %0d command words over %0d pool order settings: %0d grants, %0d frees",
                 n_words, n_orders, n_grants, n_frees);
        $display("%0d inits, %0d result words compared, %0d mismatches", n_inits, sb.checked,
                 sb.failures);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("buddy_page_allocator_core test passed");
        end else begin
            $display("buddy_page_allocator_core test failed");
        end
        $finish;
    end

endmodule
